### src/cutoff_neighbor_search_defines.svh
// Assertion macros for the cutoff neighbor search block.
`ifndef CUTOFF_NEIGHBOR_SEARCH_DEFINES_SVH
`define CUTOFF_NEIGHBOR_SEARCH_DEFINES_SVH

`ifndef ASSERT_OFF
// plain property, sampled on clk, off during reset
`define CNS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("cutoff_neighbor_search: assertion failed");
// overlapping implication
`define CNS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cutoff_neighbor_search: implication failed");
// next-cycle implication
`define CNS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cutoff_neighbor_search: next-cycle check failed");
`else
`define CNS_ASSERT(lbl, prop)
`define CNS_ASSERT_IMP(lbl, ante, cons)
`define CNS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### src/cns_pkg.sv
// Shared types and constants of the cutoff neighbor search block.
package cns_pkg;

	localparam int COORD_W    = 20;
	localparam int POS_W      = 3 * COORD_W;
	localparam int IDX_W      = 5;
	localparam int CNT_W      = 6;
	localparam int CUT_W      = 44;
	localparam int SLOT_SPACE = 32;

	// command codes
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CENTER,
		ST_LOADC,
		ST_SCAN,
		ST_CLOSE,
		ST_WAIT
	} state_t;

	// token that travels with each slot read down the distance pipeline
	typedef struct packed {
		logic             vld;
		logic             close;
		logic [IDX_W-1:0] idx;
	} tag_t;

endpackage

### src/cns_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cns_ram #(
	parameter int WIDTH = 60,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/cns_dist.sv
// Squared-distance unit: three squares in one stage, then sum and cutoff compare.
module cns_dist
	import cns_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  tag_t             tag_s1,
	input  logic [POS_W-1:0] center,
	input  logic [POS_W-1:0] pos,
	input  logic [CUT_W-1:0] cutoff,
	output tag_t             tag_s2,
	output logic             hit
);

	localparam int DIFF_W = COORD_W + 1;
	localparam int SQ_W   = 2 * COORD_W + 1;
	localparam int SUM_W  = SQ_W + 1;

	// |a - b| as an unsigned magnitude
	function automatic logic [DIFF_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b);
		logic [DIFF_W-1:0] d;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		return d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
	endfunction

	logic [DIFF_W-1:0]   mx, my, mz;
	logic [2*DIFF_W-1:0] px, py, pz;
	logic [SQ_W-1:0]     sqx_s2, sqy_s2, sqz_s2;
	logic [SUM_W-1:0]    sum;

	assign mx = abs_diff(center[COORD_W-1:0],           pos[COORD_W-1:0]);
	assign my = abs_diff(center[2*COORD_W-1:COORD_W],   pos[2*COORD_W-1:COORD_W]);
	assign mz = abs_diff(center[POS_W-1:2*COORD_W],     pos[POS_W-1:2*COORD_W]);
	assign px = mx * mx;
	assign py = my * my;
	assign pz = mz * mz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (adv) begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2 <= px[SQ_W-1:0];
			sqy_s2 <= py[SQ_W-1:0];
			sqz_s2 <= pz[SQ_W-1:0];
		end
	end

	assign sum = SUM_W'(sqx_s2) + SUM_W'(sqy_s2) + SUM_W'(sqz_s2);
	// zero distance never counts
	assign hit = (sum != '0) && (CUT_W'(sum) <= cutoff);

endmodule

### src/cutoff_neighbor_search.sv
// Top level of the brute-force cutoff neighbor search block.
//
//  channel | signals                                        | dir | beat
//  --------+------------------------------------------------+-----+---------------------------
//  in      | in_valid/in_ready, command, atom_index,        | in  | load or search command
//          | pos_x, pos_y, pos_z, atom_count                |     |
//  out     | out_valid/out_ready, neighbor_index,           | out | one neighbor, or closing
//          | is_neighbor, neighbor_count, last              |     | count beat (last = 1)
//  cfg     | cfg_valid/cfg_ready, cfg_data                  | in  | cutoff_squared write
//
// Load: written straight into the position RAM.
// Search: scans N = min(atom_count, MAX_ATOMS, 32) slots from slot 0, then sends the closing beat;
//   one slot per cycle while the output does not stall, set by the single RAM read port.
// Nothing to scan (count zero or center past the store): closing beat only.
// in_ready is low from search accept until the closing beat is taken.
// An output stall freezes the whole scan pipeline, RAM read register included.
// Reset clears control state and the cutoff; the position RAM is not cleared.
`include "cutoff_neighbor_search_defines.svh"
module cutoff_neighbor_search
	import cns_pkg::*;
#(
	parameter int MAX_ATOMS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// item input
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic [IDX_W-1:0]   atom_index,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic signed [COORD_W-1:0] pos_z,
	input  logic [CNT_W-1:0]   atom_count,
	// result output
	output logic               out_valid,
	input  logic               out_ready,
	output logic [IDX_W-1:0]   neighbor_index,
	output logic               is_neighbor,
	output logic [CNT_W-1:0]   neighbor_count,
	output logic               last,
	// configuration
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CUT_W-1:0]   cfg_data
);

	localparam int AW = $clog2(MAX_ATOMS);
	localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_ATOMS);
	// scan never goes past the store or the 5-bit slot space
	localparam logic [CNT_W-1:0] SCAN_MAX =
		(MAX_ATOMS < SLOT_SPACE) ? CNT_W'(MAX_ATOMS) : CNT_W'(SLOT_SPACE);

	state_t             state_q, state_d;
	logic [CUT_W-1:0]   cutoff_q;
	logic [IDX_W-1:0]   slot_q;
	logic [CNT_W-1:0]   limit_q;
	logic [AW-1:0]      cidx_q;
	logic [POS_W-1:0]   center_q;
	logic [CNT_W-1:0]   count_q;
	tag_t               tag_s1, tag_s2;
	logic               hit;

	logic               out_valid_q, out_nb_q, out_last_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic [CNT_W-1:0]   out_cnt_q;

	logic               adv, in_fire, search_fire, idx_ok, last_slot;
	logic [CNT_W-1:0]   cnt_lim;
	logic               rd_en, issue_vld, issue_close, cap_center;
	logic [AW-1:0]      rd_addr;
	logic               ram_we;
	logic [POS_W-1:0]   rdata;

	// pipeline moves whenever the output register is free or being drained
	assign adv         = !out_valid_q || out_ready;
	assign in_fire     = in_valid && in_ready;
	assign search_fire = in_fire && (command == CMD_SEARCH);
	assign idx_ok      = ({1'b0, atom_index} < MAX_CNT);
	assign cnt_lim     = (atom_count > SCAN_MAX) ? SCAN_MAX : atom_count;
	assign last_slot   = ({1'b0, slot_q} == (limit_q - CNT_W'(1)));

	// loads land directly; out-of-range slots are dropped
	assign ram_we = in_fire && (command == CMD_LOAD) && idx_ok;

	cns_ram #(
		.WIDTH (POS_W),
		.DEPTH (MAX_ATOMS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(atom_index)),
		.wdata ({pos_z, pos_y, pos_x}),
		.rd_en (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	cns_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.tag_s1 (tag_s1),
		.center (center_q),
		.pos    (rdata),
		.cutoff (cutoff_q),
		.tag_s2 (tag_s2),
		.hit    (hit)
	);

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (search_fire) begin
					state_d = (idx_ok && (cnt_lim != '0)) ? ST_CENTER : ST_CLOSE;
				end
			end
			ST_CENTER: begin
				if (adv) begin
					state_d = ST_LOADC;
				end
			end
			ST_LOADC:  state_d = ST_SCAN;
			ST_SCAN: begin
				if (adv && last_slot) begin
					state_d = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				if (adv) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (out_valid_q && out_ready && out_last_q) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		in_ready    = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = AW'(slot_q);
		issue_vld   = 1'b0;
		issue_close = 1'b0;
		cap_center  = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_CENTER: begin
				rd_en   = adv;
				rd_addr = cidx_q;
			end
			ST_LOADC:  cap_center = 1'b1;
			ST_SCAN: begin
				rd_en     = adv;
				issue_vld = 1'b1;
			end
			ST_CLOSE: begin
				issue_vld   = 1'b1;
				issue_close = 1'b1;
			end
			ST_WAIT:   ;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scan control and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= '0;
			limit_q  <= '0;
			cidx_q   <= '0;
			count_q  <= '0;
			cutoff_q <= '0;
			tag_s1   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cutoff_q <= cfg_data;
			end
			if (search_fire) begin
				slot_q  <= '0;
				limit_q <= cnt_lim;
				cidx_q  <= AW'(atom_index);
				count_q <= '0;
			end else if (adv) begin
				if (state_q == ST_SCAN) begin
					slot_q <= slot_q + IDX_W'(1);
				end
				if (tag_s2.vld && !tag_s2.close && hit) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (adv) begin
				tag_s1 <= '{vld: issue_vld, close: issue_close, idx: slot_q};
			end
		end
	end

	// center coordinates held for the whole scan
	always_ff @(posedge clk) begin
		if (cap_center) begin
			center_q <= rdata;
		end
	end

	// output register: one beat per hit, then the closing count beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= tag_s2.vld && (tag_s2.close || hit);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_idx_q  <= tag_s2.close ? '0 : tag_s2.idx;
			out_nb_q   <= !tag_s2.close;
			out_cnt_q  <= tag_s2.close ? count_q : (count_q + CNT_W'(1));
			out_last_q <= tag_s2.close;
		end
	end

	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign neighbor_index = out_idx_q;
	assign is_neighbor    = out_nb_q;
	assign neighbor_count = out_cnt_q;
	assign last           = out_last_q;

	// a new item is only taken with nothing left to deliver
	`CNS_ASSERT_IMP(a_ready_empty, in_ready, !out_valid_q && !tag_s1.vld && !tag_s2.vld)
	// closing beat taken returns the block to accepting items
	`CNS_ASSERT_NXT(a_close_idle, out_valid && out_ready && last, in_ready)
	// every beat is either a neighbor or the closing beat
	`CNS_ASSERT_IMP(a_beat_kind, out_valid, is_neighbor != last)
	// count never exceeds the scan length bound
	`CNS_ASSERT_IMP(a_count_max, out_valid, neighbor_count <= SCAN_MAX)

endmodule

### tb/cutoff_neighbor_search_checker.sv
// Checker: predicts the neighbor and closing beats of each search and compares them on the output channel.
`timescale 1ns / 1ps
module cutoff_neighbor_search_checker
	import cns_pkg::*;
#(
	parameter int MAX_ATOMS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic                      command,
	input  logic [IDX_W-1:0]          atom_index,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic signed [COORD_W-1:0] pos_z,
	input  logic [CNT_W-1:0]          atom_count,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [IDX_W-1:0]          neighbor_index,
	input  logic                      is_neighbor,
	input  logic [CNT_W-1:0]          neighbor_count,
	input  logic                      last,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CUT_W-1:0]          cfg_data,
	output int                        mismatches,
	output int                        pending,
	output int                        loads_seen,
	output int                        searches_seen,
	output int                        neighbor_beats,
	output int                        closing_beats
);

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} atom_pos_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             nb;
		logic [CNT_W-1:0] cnt;
		logic             fin;
	} neighbor_beat_t;

	atom_pos_t      positions [SLOT_SPACE];
	logic [CUT_W-1:0] cutoff;
	neighbor_beat_t beats_due [$];

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH %s", $realtime, what);
		mismatches++;
	endtask

	// squared distance, exact: 20 fractional bits, at most 3 * 2^40
	function automatic longint dist_sq(input atom_pos_t a, input atom_pos_t b);
		longint dx, dy, dz;
		dx = longint'(a.x) - longint'(b.x);
		dy = longint'(a.y) - longint'(b.y);
		dz = longint'(a.z) - longint'(b.z);
		return dx * dx + dy * dy + dz * dz;
	endfunction

	task automatic list_neighbors(input logic [IDX_W-1:0] center, input logic [CNT_W-1:0] cnt);
		int span;
		int found;
		longint d2;
		neighbor_beat_t b;
		span = cnt;
		if (span > MAX_ATOMS) span = MAX_ATOMS;
		if (span > SLOT_SPACE) span = SLOT_SPACE;
		found = 0;
		if (center < MAX_ATOMS) begin
			for (int j = 0; j < span; j++) begin
				d2 = dist_sq(positions[center], positions[j]);
				if (d2 > 0 && d2 <= longint'(cutoff)) begin
					found++;
					b.idx = IDX_W'(j);
					b.nb  = 1'b1;
					b.cnt = CNT_W'(found);
					b.fin = 1'b0;
					beats_due.insert(beats_due.size(), b);
				end
			end
		end
		b.idx = '0;
		b.nb  = 1'b0;
		b.cnt = CNT_W'(found);
		b.fin = 1'b1;
		beats_due.insert(beats_due.size(), b);
	endtask

	task automatic check_beat();
		neighbor_beat_t want;
		if (beats_due.size() == 0) begin
			report_mismatch($sformatf("unexpected beat idx=%0d nb=%0b cnt=%0d last=%0b",
				neighbor_index, is_neighbor, neighbor_count, last));
			return;
		end
		want = beats_due.pop_front();
		if (neighbor_index !== want.idx)
			report_mismatch($sformatf("neighbor_index %0d, want %0d", neighbor_index, want.idx));
		if (is_neighbor !== want.nb)
			report_mismatch($sformatf("is_neighbor %0b, want %0b", is_neighbor, want.nb));
		if (neighbor_count !== want.cnt)
			report_mismatch($sformatf("neighbor_count %0d, want %0d", neighbor_count, want.cnt));
		if (last !== want.fin)
			report_mismatch($sformatf("last %0b, want %0b", last, want.fin));
		if (want.fin) closing_beats++;
		else neighbor_beats++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff = '0;
			beats_due.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) cutoff = cfg_data;
			if (in_valid && in_ready) begin
				if (command == CMD_LOAD) begin
					if (atom_index < MAX_ATOMS) positions[atom_index] = '{pos_x, pos_y, pos_z};
					loads_seen++;
				end else begin
					list_neighbors(atom_index, atom_count);
					searches_seen++;
				end
			end
			if (out_valid && out_ready) check_beat();
			pending = beats_due.size();
		end
	end

endmodule

### tb/cutoff_neighbor_search_tb.sv
// Testbench top: drives loads, searches and cutoff writes, and gives the verdict.
`timescale 1ns / 1ps
module cutoff_neighbor_search_tb
	import cns_pkg::*;
();

	localparam int MAX_ATOMS   = 32;
	localparam int CYCLE_LIMIT = 200_000;
	localparam int HOLD_CYCLES = 300;	// long receiver hold-off, sender keeps offering
	localparam int PHASE_ITEMS = 30;	// random items per idling phase, three phases
	localparam logic [CUT_W-1:0] CUT_MAX = '1;
	localparam logic [CUT_W-1:0] ONE_ANG2 = CUT_W'(1) << 20;	// 1.0 in 20 fractional bits

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic                      command;
	logic [IDX_W-1:0]          atom_index;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic signed [COORD_W-1:0] pos_z;
	logic [CNT_W-1:0]          atom_count;
	logic                      out_valid;
	logic                      out_ready;
	logic [IDX_W-1:0]          neighbor_index;
	logic                      is_neighbor;
	logic [CNT_W-1:0]          neighbor_count;
	logic                      last;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CUT_W-1:0]          cfg_data;

	int mismatches, pending, loads_seen, searches_seen, neighbor_beats, closing_beats;

	// idling odds in percent, per phase
	int  sender_idle;
	int  recv_idle;
	bit  hold_go;
	int  cycles;
	int  cutoff_writes;

	// which slots hold a position; searches read only written slots
	bit  written [SLOT_SPACE];
	int  prefix;

	cutoff_neighbor_search #(.MAX_ATOMS(MAX_ATOMS)) dut (
		.clk, .arst_n,
		.in_valid, .in_ready, .command, .atom_index, .pos_x, .pos_y, .pos_z, .atom_count,
		.out_valid, .out_ready, .neighbor_index, .is_neighbor, .neighbor_count, .last,
		.cfg_valid, .cfg_ready, .cfg_data
	);

	cutoff_neighbor_search_checker #(.MAX_ATOMS(MAX_ATOMS)) u_checker (
		.clk, .arst_n,
		.in_valid, .in_ready, .command, .atom_index, .pos_x, .pos_y, .pos_z, .atom_count,
		.out_valid, .out_ready, .neighbor_index, .is_neighbor, .neighbor_count, .last,
		.cfg_valid, .cfg_ready, .cfg_data,
		.mismatches, .pending, .loads_seen, .searches_seen, .neighbor_beats, .closing_beats
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run guard: a hung handshake ends here.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d beats still due", cycles, pending);
		$display("status: fail");
		$finish;
	end

	// Receiver: random stalls at the phase's odds, plus one long hold-off on request.
	// The hold is counted here so the sender side never blocks on it.
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready = 1'b0;
			end else begin
				out_ready = ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// One input beat. Entered and left at a falling edge; valid is left high so
	// back-to-back beats need no drop. Callers lower it before going quiet.
	task automatic offer_item(input logic cmd, input logic [IDX_W-1:0] idx,
			input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [COORD_W-1:0] z, input logic [CNT_W-1:0] cnt);
		while ($urandom_range(99) < sender_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid   = 1'b1;
		command    = cmd;
		atom_index = idx;
		pos_x      = x;
		pos_y      = y;
		pos_z      = z;
		atom_count = cnt;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_atom(input logic [IDX_W-1:0] idx, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
		offer_item(CMD_LOAD, idx, x, y, z, CNT_W'($urandom));
		written[idx] = 1;
		while (prefix < SLOT_SPACE && written[prefix]) prefix++;
	endtask

	// unused position fields carry noise on a search
	task automatic search_atom(input logic [IDX_W-1:0] center, input logic [CNT_W-1:0] cnt);
		offer_item(CMD_SEARCH, center, COORD_W'($urandom), COORD_W'($urandom),
			COORD_W'($urandom), cnt);
	endtask

	// Drain: all due beats taken, then wait out any load that is still landing.
	task automatic settle();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_cutoff(input logic [CUT_W-1:0] value);
		settle();
		cfg_valid = 1'b1;
		cfg_data  = value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		cutoff_writes++;
	endtask

	// mostly a tight cluster around the origin (within 2 A), sometimes anywhere
	function automatic logic [COORD_W-1:0] pick_coord();
		if ($urandom_range(3) == 0) return COORD_W'($urandom);
		return COORD_W'(int'($urandom_range(4095)) - 2048);
	endfunction

	// Loads mostly grow the written prefix so that long scans open up; searches
	// only touch written slots.
	task automatic random_item();
		logic [IDX_W-1:0] slot;
		logic [CNT_W-1:0] cnt;
		if (prefix == 0 || $urandom_range(99) < 55) begin
			if (prefix < SLOT_SPACE && $urandom_range(3) != 0) slot = IDX_W'(prefix);
			else slot = IDX_W'($urandom);
			load_atom(slot, pick_coord(), pick_coord(), pick_coord());
		end else begin
			do slot = IDX_W'($urandom); while (!written[slot]);
			if (prefix == SLOT_SPACE) cnt = CNT_W'($urandom);
			else cnt = CNT_W'($urandom_range(prefix));
			search_atom(slot, cnt);
		end
	endtask

	initial begin
		logic [CUT_W-1:0] cut;
		in_valid      = 1'b0;
		command       = CMD_LOAD;
		atom_index    = '0;
		pos_x         = '0;
		pos_y         = '0;
		pos_z         = '0;
		atom_count    = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		hold_go       = 0;
		cutoff_writes = 0;
		prefix        = 0;
		foreach (written[i]) written[i] = 0;
		sender_idle   = 11;
		recv_idle     = 53;
		arst_n        = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: a hand-built store with known distances.
		load_atom(0, 0, 0, 0);
		load_atom(1, 20'sd1024, 0, 0);			// exactly 1.0 A from slot 0
		load_atom(2, 20'sd1025, 0, 0);			// just past 1.0 A from slot 0
		load_atom(3, 0, 0, 0);				// same spot as slot 0
		load_atom(4, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF);	// far positive corner
		load_atom(5, 20'h80000, 20'h80000, 20'h80000);	// far negative corner
		load_atom(31, 20'hFFFFF, 20'h00400, 20'hFFC00);
		search_atom(0, 6);	// cutoff still at reset value: closing beat only
		search_atom(0, 0);	// empty scan
		write_cutoff(ONE_ANG2);
		search_atom(0, 6);	// boundary slot in, zero-distance twin out
		search_atom(3, 1);	// twin of slot 0 never counts
		search_atom(1, 6);
		search_atom(31, 6);
		write_cutoff(CUT_MAX);
		search_atom(4, 6);	// corner to corner still inside the widest cutoff
		search_atom(5, 6);
		search_atom(2, 3);

		// Random phases: sender idles 11/receiver 53, then swapped, then no idling.
		for (int ph = 0; ph < 3; ph++) begin
			sender_idle = (ph == 0) ? 11 : (ph == 1) ? 53 : 0;
			recv_idle   = (ph == 0) ? 53 : (ph == 1) ? 11 : 0;
			if (ph == 0) cut = CUT_W'($urandom_range(1 << 25, 1 << 20));
			else if (ph == 1) cut = {12'($urandom_range(4095)), $urandom};
			else cut = CUT_MAX;
			write_cutoff(cut);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// long receiver hold while the sender keeps pushing items
				if (ph == 2 && n == 5 && prefix > 0) hold_go = 1;
				random_item();
			end
			if (ph == 2) begin
				// full store, then scan lengths at and past the store size
				for (int s = 0; s < SLOT_SPACE; s++)
					if (!written[s]) load_atom(IDX_W'(s), pick_coord(), pick_coord(), pick_coord());
				search_atom(IDX_W'($urandom), 6'd63);
				search_atom(IDX_W'($urandom), 6'd32);
				search_atom(IDX_W'($urandom), 6'd33);
			end
		end
		write_cutoff('0);
		search_atom(IDX_W'($urandom), 6'd63);	// zero cutoff over a full store

		settle();
		$display("covered %0d loads and %0d searches under %0d cutoff settings",
			loads_seen, searches_seen, cutoff_writes);
		$display("checked %0d neighbor beats and %0d closing beats",
			neighbor_beats, closing_beats);
		if (mismatches == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
